>>> hdl/stp_pkg.sv
package stp_pkg;

    // step_mode register codes; the unused code runs as microstep
    localparam logic [1:0] MODE_FULL  = 2'd0;
    localparam logic [1:0] MODE_HALF  = 2'd1;
    localparam logic [1:0] MODE_MICRO = 2'd2;

    // amp_kind codes
    localparam logic [1:0] KIND_MAX   = 2'd0;
    localparam logic [1:0] KIND_PAIR  = 2'd1;
    localparam logic [1:0] KIND_INDEX = 2'd2;

    // func codes
    localparam logic FUNC_STEP = 1'b0;
    localparam logic FUNC_OFF  = 1'b1;

    // dir codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 24;

    // full step bridge pattern
    function automatic logic [3:0] full_en(input logic [1:0] idx);
        logic [3:0] en;
        unique case (idx)
            2'd0:    en = 4'h9;
            2'd1:    en = 4'h5;
            2'd2:    en = 4'h6;
            default: en = 4'hA;
        endcase
        return en;
    endfunction

    // half step bridge pattern
    function automatic logic [3:0] half_en(input logic [2:0] idx);
        logic [3:0] en;
        unique case (idx)
            3'd0:    en = 4'h1;
            3'd1:    en = 4'h5;
            3'd2:    en = 4'h4;
            3'd3:    en = 4'h6;
            3'd4:    en = 4'h2;
            3'd5:    en = 4'hA;
            3'd6:    en = 4'h8;
            default: en = 4'h9;
        endcase
        return en;
    endfunction

    // half step coil A table: zero at positions 2 and 6
    function automatic logic [3:0] half_a(input logic [2:0] idx);
        return (idx[1:0] == 2'd2) ? 4'd0 : 4'd8;
    endfunction

    // half step coil B table: full only at positions 0 and 4
    function automatic logic [3:0] half_b(input logic [2:0] idx);
        return (idx[1:0] == 2'd0) ? 4'd8 : 4'd0;
    endfunction

endpackage

>>> hdl/stepper_phase_sequencer.sv
// Bipolar stepper phase sequencer. Each request on the s_axis side is one command: a step
// (tuser = 0, tdata[0] = direction, 0 forward / 1 reverse) or drive off (tuser = 1). Every
// command yields exactly one result on the m_axis side: the four bridge enables and the
// amplitude selection for the current position of the mode held in step_mode (0 full step,
// 1 half step, 2 or 3 microstep at 32 positions), after which that mode's position index
// moves by one with wraparound; the other modes' indices keep their values. Drive off
// returns all zeros and resets every index. A command is taken every clock cycle while the
// output register can take it: the position update and table lookup sit between the index
// registers and one output register, and a new request is accepted whenever that register
// is empty or being drained in the same cycle; the result is valid in the cycle after.
// Write step_mode through cfg_wen / cfg_wdata only while no command is in flight.
module stepper_phase_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration: step_mode
    input  logic                                cfg_wen,
    input  logic [1:0]                          cfg_wdata,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [stp_pkg::TDATA_IN_W-1:0]      s_axis_tdata,   // [0] dir, [7:1] zero
    input  logic                                s_axis_tuser,   // [0] func
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [stp_pkg::TDATA_OUT_W-1:0]     m_axis_tdata,   // [3:0] enables, [7:4] amp_a,
                                                                // [11:8] amp_b,
                                                                // [16:12] micro_index,
                                                                // [23:17] zero
    output logic [1:0]                          m_axis_tuser    // [1:0] amp_kind
);
    import stp_pkg::*;

    logic [1:0] step_mode_reg;
    logic [1:0] full_index_reg, full_index_next;
    logic [2:0] half_index_reg, half_index_next;
    logic [4:0] micro_pos_reg,  micro_pos_next;

    logic                   m_valid_reg;
    logic [TDATA_OUT_W-1:0] m_data_reg;
    logic [1:0]             m_user_reg;

    logic       in_accept;
    logic       cmd_func;
    logic       cmd_dir;
    logic [3:0] en_next;
    logic [1:0] kind_next;
    logic [3:0] amp_a_next;
    logic [3:0] amp_b_next;
    logic [4:0] mi_next;

    // Output register frees up when it is empty or its result leaves this cycle.
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cmd_func      = s_axis_tuser;
    assign cmd_dir       = s_axis_tdata[0];

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Look up the current position, then advance or retreat the active mode's index.
    always_comb begin
        full_index_next = full_index_reg;
        half_index_next = half_index_reg;
        micro_pos_next  = micro_pos_reg;
        en_next         = 4'd0;
        kind_next       = KIND_MAX;
        amp_a_next      = 4'd0;
        amp_b_next      = 4'd0;
        mi_next         = 5'd0;
        if (cmd_func == FUNC_OFF) begin
            // drop the drive and home every index
            full_index_next = '0;
            half_index_next = '0;
            micro_pos_next  = '0;
        end else begin
            unique case (step_mode_reg)
                MODE_FULL: begin
                    en_next         = full_en(full_index_reg);
                    kind_next       = KIND_MAX;
                    full_index_next = (cmd_dir == DIR_REV) ? full_index_reg - 2'd1
                                                           : full_index_reg + 2'd1;
                end
                MODE_HALF: begin
                    en_next         = half_en(half_index_reg);
                    kind_next       = KIND_PAIR;
                    amp_a_next      = half_a(half_index_reg);
                    amp_b_next      = half_b(half_index_reg);
                    half_index_next = (cmd_dir == DIR_REV) ? half_index_reg - 3'd1
                                                           : half_index_reg + 3'd1;
                end
                default: begin
                    // microstep; the unused mode code runs here as well
                    en_next        = full_en(micro_pos_reg[4:3]);
                    kind_next      = KIND_INDEX;
                    mi_next        = micro_pos_reg;
                    micro_pos_next = (cmd_dir == DIR_REV) ? micro_pos_reg - 5'd1
                                                          : micro_pos_reg + 5'd1;
                end
            endcase
        end
    end

    // Control state and indices.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_mode_reg  <= MODE_FULL;
            full_index_reg <= '0;
            half_index_reg <= '0;
            micro_pos_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wen) begin
                step_mode_reg <= cfg_wdata;
            end
            if (in_accept) begin
                full_index_reg <= full_index_next;
                half_index_reg <= half_index_next;
                micro_pos_reg  <= micro_pos_next;
                m_valid_reg    <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; hold while the sink stalls.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {7'd0, mi_next, amp_b_next, amp_a_next, en_next};
            m_user_reg <= kind_next;
        end
    end

`ifndef SYNTHESIS
    // A drive off command homes all indices.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && cmd_func == FUNC_OFF) |=>
            (full_index_reg == '0 && half_index_reg == '0 && micro_pos_reg == '0))
        else $error("indices not cleared after drive off");

    // The output kind never carries the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_user_reg == KIND_MAX || m_user_reg == KIND_PAIR ||
                         m_user_reg == KIND_INDEX))
        else $error("invalid amp_kind on output");

    // Coil pair fields are only nonzero for half step results.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != KIND_PAIR) |-> (m_data_reg[11:4] == 8'd0))
        else $error("coil pair set outside half step");

    // The microstep index only appears with a microstep result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_user_reg != KIND_INDEX) |-> (m_data_reg[16:12] == 5'd0))
        else $error("micro_index set outside microstep");

    // Indices move only when a request is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(in_accept) |-> ($stable(full_index_reg) && $stable(half_index_reg) &&
                               $stable(micro_pos_reg)))
        else $error("index moved without a request");
`endif

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import stp_pkg::*;

    // one command as it travels on the s_axis side
    typedef struct packed {
        logic func;
        logic dir;
    } cmd_t;

    // one result as it leaves on the m_axis side
    typedef struct packed {
        logic [6:0] pad;
        logic [4:0] micro_index;
        logic [3:0] amp_b;
        logic [3:0] amp_a;
        logic [3:0] enables;
        logic [1:0] amp_kind;
    } phase_out_t;

    // bridge patterns and half step coil tables, one nibble per position, position 0 lowest
    localparam logic [15:0] FULL_PATTERN = 16'hA659;
    localparam logic [31:0] HALF_PATTERN = 32'h98A26451;
    localparam logic [31:0] HALF_COIL_A  = 32'h80888088;
    localparam logic [31:0] HALF_COIL_B  = 32'h00080008;

    // unused step_mode code, which the sequencer runs as microstep
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int IDLE_PCT    = 21;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic       cfg_wen   = 1'b0;
    logic [1:0] cfg_wdata = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    stepper_phase_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // commands waiting to be offered, and results the sequencer still owes
    cmd_t       pending_cmds[$];
    phase_out_t owed_results[$];

    // shadow of step_mode and of the three position indices
    logic [1:0] mode_q    = MODE_FULL;
    logic [1:0] full_pos  = '0;
    logic [2:0] half_pos  = '0;
    logic [4:0] micro_pos = '0;

    logic s_fire      = 1'b0;
    bit   no_idle     = 1'b0;
    int   hold_asked  = 0;
    int   hold_served = 0;
    int   hold_left   = 0;

    int   errors      = 0;
    int   cycles      = 0;
    int   results_ok  = 0;
    int   drive_offs  = 0;
    int   mode_writes = 0;
    int   steps_in_mode[4] = '{0, 0, 0, 0};

    // Work out the result of one command and move the shadow indices the way the
    // sequencer must: only the active mode's index moves on a step, drive off clears all.
    function automatic phase_out_t next_phase(input logic func, input logic dir);
        phase_out_t r;
        r = '0;
        if (func == FUNC_OFF) begin
            full_pos  = '0;
            half_pos  = '0;
            micro_pos = '0;
        end else begin
            case (mode_q)
                MODE_FULL: begin
                    r.enables  = FULL_PATTERN[{full_pos, 2'b00} +: 4];
                    r.amp_kind = KIND_MAX;
                    full_pos   = (dir == DIR_REV) ? full_pos - 2'd1 : full_pos + 2'd1;
                end
                MODE_HALF: begin
                    r.enables  = HALF_PATTERN[{half_pos, 2'b00} +: 4];
                    r.amp_a    = HALF_COIL_A[{half_pos, 2'b00} +: 4];
                    r.amp_b    = HALF_COIL_B[{half_pos, 2'b00} +: 4];
                    r.amp_kind = KIND_PAIR;
                    half_pos   = (dir == DIR_REV) ? half_pos - 3'd1 : half_pos + 3'd1;
                end
                default: begin
                    // microstep, also taken by the unused mode code
                    r.enables     = FULL_PATTERN[{micro_pos[4:3], 2'b00} +: 4];
                    r.micro_index = micro_pos;
                    r.amp_kind    = KIND_INDEX;
                    micro_pos     = (dir == DIR_REV) ? micro_pos - 5'd1 : micro_pos + 5'd1;
                end
            endcase
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // free-running clock, 4 ns period
    initial begin
        forever #2 aclk = ~aclk;
    end

    // watchdog: end the run if it hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles,
                     owed_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    // Sender: hold a request until it is taken, then offer the next one or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_fire) begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= pending_cmds[0].func;
                s_axis_tdata  <= {{(TDATA_IN_W-1){1'b0}}, pending_cmds[0].dir};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Take accepted requests off the queue and log what the sequencer owes for them.
    always @(posedge aclk) begin
        s_fire <= s_axis_tvalid && s_axis_tready;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            void'(pending_cmds.pop_front());
            if (s_axis_tuser == FUNC_OFF)
                drive_offs++;
            else
                steps_in_mode[mode_q]++;
            owed_results.push_back(next_phase(s_axis_tuser, s_axis_tdata[0]));
        end
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_served   <= hold_served + 1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare every accepted result with the oldest one owed, field by field.
    always @(posedge aclk) begin
        phase_out_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[23:17], m_axis_tdata[16:12], m_axis_tdata[11:8],
                   m_axis_tdata[7:4], m_axis_tdata[3:0], m_axis_tuser};
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("enables", int'(want.enables), int'(got.enables));
                check_field("amp_kind", int'(want.amp_kind), int'(got.amp_kind));
                check_field("amp_a", int'(want.amp_a), int'(got.amp_a));
                check_field("amp_b", int'(want.amp_b), int'(got.amp_b));
                check_field("micro_index", int'(want.micro_index), int'(got.micro_index));
                check_field("tdata pad", int'(want.pad), int'(got.pad));
                if (got == want)
                    results_ok++;
            end
        end
    end

    task automatic push_cmd(input logic func, input logic dir);
        cmd_t c;
        c.func = func;
        c.dir  = dir;
        pending_cmds.push_back(c);
    endtask

    // Wait until every request is taken and every result is back, then settle a little.
    task automatic wait_drained();
        while (pending_cmds.size() > 0 || owed_results.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Write step_mode; only called with the sequencer idle.
    task automatic write_mode(input logic [1:0] mode);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= mode;
        mode_q     = mode;
        mode_writes++;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Random commands: mostly runs in one direction so the indices travel and wrap,
    // with occasional reversals and a sparse drive off.
    task automatic random_cmds(input int count, input int off_pct);
        logic run_dir;
        run_dir = 1'($urandom_range(1));
        repeat (count) begin
            if ($urandom_range(99) < 15)
                run_dir = ~run_dir;
            if ($urandom_range(99) < off_pct)
                push_cmd(FUNC_OFF, 1'($urandom_range(1)));
            else
                push_cmd(FUNC_STEP, run_dir);
        end
    endtask

    initial begin
        logic [1:0] mode;
        // hold reset, release at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset mode is full step. Reverse from zero wraps to the top position.
        push_cmd(FUNC_STEP, DIR_REV);
        repeat (4) push_cmd(FUNC_STEP, DIR_FWD);
        push_cmd(FUNC_OFF, DIR_FWD);
        wait_drained();

        // half step: wrap down, walk up, drive off with reverse flag set
        write_mode(MODE_HALF);
        repeat (2) push_cmd(FUNC_STEP, DIR_REV);
        repeat (3) push_cmd(FUNC_STEP, DIR_FWD);
        push_cmd(FUNC_OFF, DIR_REV);
        wait_drained();

        // microstep: reverse from zero lands on the last position
        write_mode(MODE_MICRO);
        repeat (2) push_cmd(FUNC_STEP, DIR_REV);
        push_cmd(FUNC_STEP, DIR_FWD);
        wait_drained();

        // unused mode code runs as microstep and keeps the microstep position
        write_mode(MODE_SPARE);
        repeat (2) push_cmd(FUNC_STEP, DIR_FWD);
        push_cmd(FUNC_STEP, DIR_REV);
        wait_drained();

        // back to full step without drive off: its index must have been kept
        write_mode(MODE_FULL);
        repeat (2) push_cmd(FUNC_STEP, DIR_FWD);
        push_cmd(FUNC_OFF, DIR_REV);
        wait_drained();

        // Random phases: first visit every mode in order, then pick at random.
        for (int p = 0; p < 13; p++) begin
            mode = (p < 4) ? p[1:0] : 2'($urandom_range(3));
            write_mode(mode);
            if (p == 5)
                no_idle = 1'b1;
            if (p == 7)
                hold_asked++;
            random_cmds(100, (p % 3 == 0) ? 2 : 6);
            wait_drained();
            no_idle = 1'b0;
        end

        // drain: nothing owed, give the output register a few more cycles
        wait_drained();
        repeat (5) @(posedge aclk);

        $display("covered %0d full, %0d half, %0d micro, %0d unused-mode steps and %0d drive offs",
                 steps_in_mode[0], steps_in_mode[1], steps_in_mode[2], steps_in_mode[3],
                 drive_offs);
        $display("across %0d mode writes; %0d results matched, %0d mismatches",
                 mode_writes, results_ok, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> stepper_phase_sequencer.f
hdl/stp_pkg.sv
hdl/stepper_phase_sequencer.sv
tb/sv/tb.sv
